[hdl/twe_pkg.sv]
// Shared types and constants for the trie word engine.
`default_nettype none

package twe_pkg;

    localparam int NODE_COUNT_DEF    = 1024;
    localparam int ALPHABET_SIZE_DEF = 26;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_PREFIX = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_END
    } t_state;

    typedef struct packed {
        logic child_re;
        logic child_we;
        logic end_re;
        logic end_we;
    } t_mem_ctl;

endpackage

`default_nettype wire

[hdl/twe_mem.sv]
// Child-index and word-end memories of the trie with their power-up clearing sweep.
`default_nettype none

module twe_mem #(
    parameter int NODE_COUNT    = twe_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = twe_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire twe_pkg::t_mem_ctl                            i_ctl,
    input  wire logic [$clog2(NODE_COUNT*ALPHABET_SIZE)-1:0]  i_child_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0]                i_child_wdata,
    input  wire logic [$clog2(NODE_COUNT)-1:0]                i_end_addr,
    output logic      [$clog2(NODE_COUNT)-1:0]                o_child_rdata,
    output logic                                              o_end_rdata,
    output logic                                              o_busy
);
    import twe_pkg::*;

    localparam int DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODE_COUNT);

    logic [NW-1:0] mem_child [DEPTH];
    logic          mem_end   [NODE_COUNT];

    logic [AW-1:0] r_clr_addr;
    logic          r_busy;
    logic [NW-1:0] r_child_rdata;
    logic          r_end_rdata;

    // sweep every entry to zero after reset, one address a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem_child[r_clr_addr] <= '0;
        end else if (i_ctl.child_we) begin
            mem_child[i_child_addr] <= i_child_wdata;
        end
        if (i_ctl.child_re) begin
            r_child_rdata <= mem_child[i_child_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_clr_addr < AW'(NODE_COUNT)) begin
                mem_end[r_clr_addr[NW-1:0]] <= 1'b0;
            end
        end else if (i_ctl.end_we) begin
            mem_end[i_end_addr] <= 1'b1;
        end
        if (i_ctl.end_re) begin
            r_end_rdata <= mem_end[i_end_addr];
        end
    end

    assign o_child_rdata = r_child_rdata;
    assign o_end_rdata   = r_end_rdata;
    assign o_busy        = r_busy;

endmodule

`default_nettype wire

[hdl/trie_word_engine_unit.sv]
// Top level of the trie word engine: letter walk, node allocation and result register.
//
//  channel | dir | tdata                      | tuser                     | tlast
//  --------+-----+----------------------------+---------------------------+------
//  s_*     | in  | [4:0] letter, [5] first    | [1:0] cmd, [2] has_letter | last
//  m_*     | out | [0] found, [1] pool_full   | [1:0] op_done             | -
//
// An item is accepted together with its child-table read, then evaluated and written back.
// For the last item of a whole-word search the word-end bit is read and checked in S_END.
// After reset a clearing pass over all NODE_COUNT*ALPHABET_SIZE entries (26624 by default)
// runs before the first item is accepted.
// A result waits in the output register; the step that writes it holds while it is full.
`default_nettype none

module trie_word_engine_unit #(
    parameter int NODE_COUNT    = twe_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = twe_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [4:0] letter, [5] first
    input  wire logic [2:0] i_s_tuser,   // [1:0] cmd, [2] has_letter
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata,   // [0] found, [1] pool_full
    output logic      [1:0] o_m_tuser    // [1:0] op_done
);
    import twe_pkg::*;

    localparam int AW = $clog2(NODE_COUNT * ALPHABET_SIZE);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);

    t_state        r_state,     n_state;
    logic [NW-1:0] r_cur,       n_cur;
    logic          r_failed,    n_failed;
    logic [FW-1:0] r_next_free, n_next_free;
    t_cmd          r_cmd,       n_cmd;
    logic          r_step,      n_step;
    logic          r_last,      n_last;
    logic [AW-1:0] r_slot,      n_slot;
    logic          r_out_valid, n_out_valid;
    t_cmd          r_out_cmd,   n_out_cmd;
    logic          r_out_found, n_out_found;
    logic          r_out_full,  n_out_full;

    t_mem_ctl      w_ctl;
    logic [AW-1:0] w_child_addr;
    logic [NW-1:0] w_child_rdata;
    logic          w_end_rdata;
    logic          w_busy;

    t_cmd          w_in_cmd;
    logic          w_accept;
    logic          w_letter_ok;
    logic [NW-1:0] w_base_node;
    logic [AW-1:0] w_slot;
    logic          w_do_step;
    logic          w_alloc;
    logic          w_miss;
    logic [NW-1:0] w_node;
    logic          w_fail;
    logic          w_out_free;

    twe_mem #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_mem (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_child_addr  (w_child_addr),
        .i_child_wdata (r_next_free[NW-1:0]),
        .i_end_addr    (w_node),
        .o_child_rdata (w_child_rdata),
        .o_end_rdata   (w_end_rdata),
        .o_busy        (w_busy)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_cmd   = t_cmd'(i_s_tuser[1:0]);

    assign w_letter_ok = i_s_tuser[2] && (9'(i_s_tdata[4:0]) < 9'(ALPHABET_SIZE));
    assign w_base_node = i_s_tdata[5] ? '0 : r_cur;
    assign w_slot      = AW'(w_base_node) * AW'(ALPHABET_SIZE)
                       + (w_letter_ok ? AW'(i_s_tdata[4:0]) : '0);
    assign w_child_addr = (r_state == S_IDLE) ? w_slot : r_slot;

    // walk step on the child entry read for the held item
    assign w_do_step = r_step && !r_failed;
    assign w_alloc   = w_do_step && (w_child_rdata == '0) && (r_cmd == CMD_INSERT)
                     && (r_next_free < FW'(NODE_COUNT));
    assign w_miss    = w_do_step && (w_child_rdata == '0) && !w_alloc;
    assign w_node    = (r_state == S_END) ? r_cur :
                       w_alloc             ? r_next_free[NW-1:0] :
                       (w_do_step && !w_miss) ? w_child_rdata : r_cur;
    assign w_fail    = r_failed || w_miss;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_failed    = r_failed;
        n_next_free = r_next_free;
        n_cmd       = r_cmd;
        n_step      = r_step;
        n_last      = r_last;
        n_slot      = r_slot;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_cmd   = r_out_cmd;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        w_ctl       = '0;

        unique case (r_state)
            S_CLEAR: begin
                if (!w_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // drop operation code three without touching state
                if (w_accept && w_in_cmd != CMD_NONE) begin
                    w_ctl.child_re = 1'b1;
                    n_cmd   = w_in_cmd;
                    n_step  = w_letter_ok;
                    n_last  = i_s_tlast;
                    n_slot  = w_slot;
                    n_state = S_EVAL;
                    if (i_s_tdata[5]) begin
                        n_cur    = '0;
                        n_failed = 1'b0;
                    end
                end
            end
            S_EVAL: begin
                // for a last insert or prefix item, hold until the output register can take the result
                if (!(r_last && r_cmd != CMD_SEARCH && !w_out_free)) begin
                    n_cur    = w_node;
                    n_failed = w_fail;
                    n_state  = S_IDLE;
                    if (w_alloc) begin
                        w_ctl.child_we = 1'b1;
                        n_next_free    = r_next_free + 1'b1;
                    end
                    if (r_last) begin
                        unique case (r_cmd)
                            CMD_INSERT: begin
                                w_ctl.end_we = !w_fail;
                                n_out_valid  = 1'b1;
                                n_out_cmd    = r_cmd;
                                n_out_found  = !w_fail;
                                n_out_full   = w_fail;
                            end
                            CMD_SEARCH: begin
                                w_ctl.end_re = 1'b1;
                                n_state      = S_END;
                            end
                            CMD_PREFIX: begin
                                n_out_valid = 1'b1;
                                n_out_cmd   = r_cmd;
                                n_out_found = !w_fail;
                                n_out_full  = 1'b0;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_END: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cmd   = r_cmd;
                    n_out_found = !r_failed && w_end_rdata;
                    n_out_full  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_failed    <= 1'b0;
            r_next_free <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_failed    <= n_failed;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_step      <= n_step;
        r_last      <= n_last;
        r_slot      <= n_slot;
        r_out_cmd   <= n_out_cmd;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_full, r_out_found};
    assign o_m_tuser  = r_out_cmd;

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the trie word engine: directed, random and pool exhaustion runs.
`timescale 1ns / 100ps

module tb_top;
    import twe_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int ALPHA       = ALPHABET_SIZE_DEF;
    localparam int MAX_LEN     = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 20;
    localparam logic [4:0] LTR_A = 5'd0;
    localparam logic [4:0] LTR_B = 5'd1;
    localparam logic [4:0] LTR_F = 5'd5;
    localparam logic [4:0] LTR_G = 5'd6;
    localparam logic [4:0] LTR_Z = 5'd25;

    typedef struct packed {
        t_cmd op;
        logic found;
        logic full;
    } t_result;

    typedef struct packed {
        logic [4:0]        len;
        logic [15:0][4:0]  txt;
    } t_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic [2:0] i_s_tuser;
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic [1:0] o_m_tuser;

    // predicted trie contents
    logic [9:0]  child_mem [0:NODES*ALPHA-1];
    bit          word_end  [0:NODES-1];
    logic [10:0] free_ptr;
    logic [9:0]  cur_node;
    bit          walk_dead;

    t_result results_due[$];
    t_word   known_words[$];
    t_result got_r;
    int      err_count;
    int      items_sent;
    int      cycle_count;
    bit      gaps_on;
    bit      stall_on;

    trie_word_engine_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void trie_walk(t_cmd op, logic [4:0] ltr, logic has, logic fst,
                                      logic lst);
        int         slot;
        logic [9:0] nxt;
        t_result    r;
        if (op == CMD_NONE)
            return;
        if (fst) begin
            cur_node  = '0;
            walk_dead = 1'b0;
        end
        if (has && ltr < ALPHA && !walk_dead) begin
            slot = int'(cur_node) * ALPHA + int'(ltr);
            nxt  = child_mem[slot];
            if (nxt == '0) begin
                if (op == CMD_INSERT && free_ptr < NODES) begin
                    nxt             = free_ptr[9:0];
                    child_mem[slot] = nxt;
                    free_ptr++;
                end else begin
                    walk_dead = 1'b1;
                end
            end
            if (!walk_dead)
                cur_node = nxt;
        end
        if (!lst)
            return;
        r.op    = op;
        r.found = 1'b0;
        r.full  = 1'b0;
        case (op)
            CMD_INSERT: begin
                if (walk_dead) begin
                    r.full = 1'b1;
                end else begin
                    word_end[cur_node] = 1'b1;
                    r.found            = 1'b1;
                end
            end
            CMD_SEARCH: r.found = !walk_dead && word_end[cur_node];
            default:    r.found = !walk_dead;
        endcase
        results_due.push_back(r);
    endfunction

    // Check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result transaction: op_done %0d", o_m_tuser);
                err_count++;
            end else begin
                got_r = results_due.pop_front();
                if (o_m_tuser !== got_r.op) begin
                    $error("op_done: expected %0d, got %0d", got_r.op, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[0] !== got_r.found) begin
                    $error("found: expected %0d, got %0d", got_r.found, o_m_tdata[0]);
                    err_count++;
                end
                if (o_m_tdata[1] !== got_r.full) begin
                    $error("pool_full: expected %0d, got %0d", got_r.full, o_m_tdata[1]);
                    err_count++;
                end
            end
        end
    end

    // Result side backpressure: short and long stalls, with quiet stretches.
    initial begin
        int r;
        int n_low;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r     = $urandom_range(0, 99);
            n_low = 0;
            if (stall_on && r < 8)
                n_low = $urandom_range(20, 80);
            else if (stall_on && r < 45)
                n_low = $urandom_range(1, 3);
            if (n_low > 0) begin
                i_m_tready <= 1'b0;
                repeat (n_low) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ((r >= 92) ? 60 : $urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    task automatic send_item(t_cmd op, logic [4:0] ltr, logic has, logic fst, logic lst);
        int r;
        int gap;
        gap = 0;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 40);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, fst, ltr};
        i_s_tuser  <= {has, op};
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        trie_walk(op, ltr, has, fst, lst);
        if (op != CMD_NONE)
            items_sent++;
    endtask

    task automatic send_word(t_cmd op, t_word w, bit mixed, bit no_first, bit no_last);
        t_cmd c;
        if (w.len == 0) begin
            send_item(op, 5'($urandom_range(0, 31)), 1'b0, !no_first, !no_last);
        end else begin
            for (int i = 0; i < int'(w.len); i++) begin
                c = mixed ? t_cmd'($urandom_range(0, 2)) : op;
                send_item(c, w.txt[i], 1'b1, (i == 0) && !no_first,
                          (i == int'(w.len) - 1) && !no_last);
            end
        end
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_word make_word(int len, int span);
        t_word w;
        w.len = 5'(len);
        for (int i = 0; i < MAX_LEN; i++)
            w.txt[i] = (i < len) ? 5'($urandom_range(0, span - 1)) : 5'd0;
        return w;
    endfunction

    function automatic t_word pick_known();
        return known_words[$urandom_range(0, known_words.size() - 1)];
    endfunction

    function automatic void remember(t_word w);
        if (known_words.size() >= 200)
            known_words.delete($urandom_range(0, 199));
        known_words.push_back(w);
    endfunction

    task automatic run_word_traffic(int count);
        int    r;
        int    stop_at;
        t_word w;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (known_words.size() == 0 && r >= 35 && r < 75)
                r = 0;
            if (r < 3) begin
                send_word(t_cmd'($urandom_range(0, 2)), make_word(0, 1), 0, 0, 0);
            end else if (r < 35) begin
                w = make_word($urandom_range(1, 8), ($urandom_range(0, 4) == 0) ? ALPHA : 4);
                send_word(CMD_INSERT, w, 0, 0, 0);
                remember(w);
            end else if (r < 60) begin
                w = pick_known();
                if ($urandom_range(0, 3) == 0)
                    w.len = 5'($urandom_range(0, w.len));
                else if ($urandom_range(0, 3) == 0 && w.len < MAX_LEN) begin
                    w.txt[w.len] = 5'($urandom_range(0, 3));
                    w.len++;
                end
                send_word(CMD_SEARCH, w, 0, 0, 0);
            end else if (r < 75) begin
                w     = pick_known();
                w.len = 5'($urandom_range(0, w.len));
                send_word(CMD_PREFIX, w, 0, 0, 0);
            end else if (r < 82) begin
                send_word(t_cmd'($urandom_range(1, 2)), make_word($urandom_range(1, 6), 6),
                          0, 0, 0);
            end else if (r < 90) begin
                // broken sequences: mixed operations, dropped first or last marks
                send_word(t_cmd'($urandom_range(0, 2)), make_word($urandom_range(1, 6), 4),
                          $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                send_item(t_cmd'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_directed_cases();
        // empty word on an empty trie, then stored
        send_item(CMD_SEARCH, LTR_A, 1'b0, 1'b1, 1'b1);
        send_item(CMD_PREFIX, LTR_Z, 1'b0, 1'b1, 1'b1);
        send_item(CMD_INSERT, 5'd31, 1'b0, 1'b1, 1'b1);
        send_item(CMD_SEARCH, LTR_A, 1'b0, 1'b1, 1'b1);
        // extreme letters
        send_item(CMD_INSERT, LTR_A, 1'b1, 1'b1, 1'b0);
        send_item(CMD_INSERT, LTR_Z, 1'b1, 1'b0, 1'b1);
        send_item(CMD_SEARCH, LTR_A, 1'b1, 1'b1, 1'b1);
        send_item(CMD_PREFIX, LTR_A, 1'b1, 1'b1, 1'b1);
        send_item(CMD_SEARCH, LTR_A, 1'b1, 1'b1, 1'b0);
        send_item(CMD_SEARCH, LTR_Z, 1'b1, 1'b0, 1'b1);
        // search miss, later letters ignored
        send_item(CMD_SEARCH, LTR_Z, 1'b1, 1'b1, 1'b0);
        send_item(CMD_SEARCH, LTR_A, 1'b1, 1'b0, 1'b0);
        send_item(CMD_PREFIX, LTR_Z, 1'b1, 1'b0, 1'b1);
        // letters outside the alphabet do not move the walk
        send_item(CMD_INSERT, LTR_A, 1'b1, 1'b1, 1'b0);
        send_item(CMD_INSERT, 5'd31, 1'b1, 1'b0, 1'b1);
        send_item(CMD_SEARCH, 5'd26, 1'b1, 1'b1, 1'b1);
        // continue without a first mark from where the last word stopped
        send_item(CMD_INSERT, LTR_B, 1'b1, 1'b0, 1'b1);
        send_item(CMD_SEARCH, LTR_B, 1'b1, 1'b0, 1'b1);
        // mixed operations: a failed search walk ended by an insert
        send_item(CMD_SEARCH, LTR_F, 1'b1, 1'b1, 1'b0);
        send_item(CMD_INSERT, LTR_G, 1'b1, 1'b0, 1'b1);
        // failure survives the last mark until the next first mark
        send_item(CMD_PREFIX, LTR_A, 1'b1, 1'b0, 1'b1);
        send_item(CMD_PREFIX, LTR_A, 1'b1, 1'b1, 1'b1);
        wait_all_results();
    endtask

    task automatic test_ignored_items();
        t_word w;
        for (int i = 0; i < 8; i++)
            send_item(CMD_NONE, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        // an ignored item with first and last inside a word must not restart it
        w = make_word(4, 4);
        send_item(CMD_INSERT, w.txt[0], 1'b1, 1'b1, 1'b0);
        send_item(CMD_INSERT, w.txt[1], 1'b1, 1'b0, 1'b0);
        send_item(CMD_NONE, LTR_Z, 1'b1, 1'b1, 1'b1);
        send_item(CMD_INSERT, w.txt[2], 1'b1, 1'b0, 1'b0);
        send_item(CMD_INSERT, w.txt[3], 1'b1, 1'b0, 1'b1);
        w.len = 5'd4;
        send_word(CMD_SEARCH, w, 0, 0, 0);
        remember(w);
        wait_all_results();
    endtask

    task automatic test_random_words();
        run_word_traffic(200);
        wait_all_results();
    endtask

    task automatic test_pool_exhaustion();
        t_word w;
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        while (free_ptr < NODES) begin
            if (free_ptr > NODES / 2) begin
                gaps_on  = 1'b1;
                stall_on = 1'b1;
            end
            w = make_word(MAX_LEN, ALPHA);
            send_word(CMD_INSERT, w, 0, 0, 0);
            remember(w);
        end
        for (int i = 0; i < 6; i++)
            send_word(CMD_INSERT, make_word($urandom_range(2, 6), ALPHA), 0, 0, 0);
        for (int i = 0; i < 10; i++) begin
            w = pick_known();
            send_word(t_cmd'($urandom_range(0, 2)), w, 0, 0, 0);
        end
        wait_all_results();
    endtask

    task automatic test_full_pool_traffic();
        run_word_traffic(100);
        wait_all_results();
    endtask

    initial begin
        err_count  = 0;
        items_sent = 0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        for (int i = 0; i < NODES * ALPHA; i++)
            child_mem[i] = '0;
        for (int i = 0; i < NODES; i++)
            word_end[i] = 1'b0;
        free_ptr   = 11'd1;
        cur_node   = '0;
        walk_dead  = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_ignored_items();
        test_random_words();
        test_pool_exhaustion();
        test_full_pool_traffic();

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/twe_pkg.sv
hdl/twe_mem.sv
hdl/trie_word_engine_unit.sv
test/tb_top.sv
